FILE: src/asmc_pkg.sv
package asmc_pkg;

  // Default sizes of the cost table
  localparam int ALPHABET_SIZE_DEF = 8;
  localparam int COST_WIDTH_DEF    = 16;

  // Fixed field widths on the stream ports
  localparam int SET_W      = 8;
  localparam int STATE_W    = 3;
  localparam int COST_IO_W  = 16;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 24;

  // Input kinds carried on s_tuser
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Query sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_CHAIN,
    ST_DONE
  } asmc_state_t;

  // Strobes broadcast from the sequencer to every cell
  typedef struct packed {
    logic wr_en;   // table write transaction, column and data valid
    logic clear;   // new query: drop row and chain accumulators
    logic sweep;   // fold one column into the row accumulator
    logic chain;   // hand partial result one cell down the row
  } asmc_ctrl_t;

endpackage

FILE: src/ambiguous_state_min_cost_top.sv
// Ambiguous-state minimum-cost lookup.
// Input stream (s_*): s_tuser selects the kind of transaction. A write stores
// one cost at (row_state, column_state) of the cost table and gives no result;
// rows or columns outside the alphabet are dropped. A query carries two state
// bitmasks and gives one result on the output stream (m_*): the least table
// cost over all pairs of the two sets and the union of the states of every
// minimum-cost pair. m_tuser flags a query with an empty set; min_cost then
// reads all ones and median_set zero. Only entries already written may be
// reached by a query.
// Timing: writes and queries are taken only while no query is in flight. A
// query sweeps the columns, each cell folding its row, then passes the
// partial result through the row of ALPHABET_SIZE cells, one cell per cycle;
// the result lands in the output register, and the input is ready again
// from that same cycle, so a new query is not taken before the last one
// is through.
// A stalled receiver holds the result in the output register; writes and the
// next query are still taken, and a finished query waits until that register
// frees. Reset empties the output register and the sequencer; table contents
// are undefined until written.
module ambiguous_state_min_cost_top import asmc_pkg::*; #(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int COST_WIDTH    = COST_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // first_set[7:0], second_set[15:8], row_state[18:16],
  // column_state[21:19], cost_value[37:22], zero fill[39:38]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // mode[0]
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // min_cost[15:0], median_set[23:16]
  output logic [M_TDATA_W-1:0] m_tdata,
  // no_pair[0]
  output logic                 m_tuser
);

  localparam int N   = ALPHABET_SIZE;
  localparam int CIW = $clog2(N);
  localparam int IXW = CIW + STATE_W;

  asmc_state_t state, state_next;
  logic [CIW-1:0] cnt, cnt_next;
  asmc_ctrl_t     ctrl;
  logic           load_out;

  logic [SET_W-1:0] first_q, second_q;
  logic [N-1:0]     first_m, second_m;
  logic [SET_W-1:0] col_bit;

  logic [SET_W-1:0]      s_first, s_second;
  logic [STATE_W-1:0]    s_row, s_col;
  logic [COST_IO_W-1:0]  s_cost;
  logic [IXW-1:0]        row_x, col_x;
  logic                  wr_ok;
  logic [COST_IO_W+COST_WIDTH-1:0] cost_x;
  logic [COST_WIDTH-1:0] wr_cost;

  logic [COST_WIDTH-1:0] c_best [N+1];
  logic [SET_W-1:0]      c_med  [N+1];
  logic                  c_any  [N+1];

  logic [COST_IO_W+COST_WIDTH-1:0] best_x;
  logic [COST_IO_W-1:0]  res_cost;
  logic [SET_W-1:0]      res_med;
  logic                  accept;

  // Field unpacking
  assign s_first  = s_tdata[7:0];
  assign s_second = s_tdata[15:8];
  assign s_row    = s_tdata[18:16];
  assign s_col    = s_tdata[21:19];
  assign s_cost   = s_tdata[37:22];

  assign row_x   = {{CIW{1'b0}}, s_row};
  assign col_x   = {{CIW{1'b0}}, s_col};
  assign wr_ok   = (row_x < IXW'(N)) && (col_x < IXW'(N));
  assign cost_x  = {{COST_WIDTH{1'b0}}, s_cost};
  assign wr_cost = cost_x[COST_WIDTH-1:0];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Query sets, held for the whole sweep
  always_ff @(posedge clk) begin
    if (accept && s_tuser == MODE_QUERY) begin
      first_q  <= s_first;
      second_q <= s_second;
    end
  end

  // States beyond the alphabet drop out here
  always_comb begin
    logic [N+SET_W-1:0] fx, sx;
    fx       = {{N{1'b0}}, first_q};
    sx       = {{N{1'b0}}, second_q};
    first_m  = fx[N-1:0];
    second_m = sx[N-1:0];
  end

  assign col_bit = (IXW'(cnt) < IXW'(SET_W)) ? (SET_W'(1) << cnt) : '0;

  // Sequencer state and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctrl       = '0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == MODE_QUERY) begin
            ctrl.clear = 1'b1;
            cnt_next   = '0;
            state_next = ST_SWEEP;
          end else begin
            ctrl.wr_en = wr_ok;
          end
        end
      end
      ST_SWEEP: begin
        ctrl.sweep = 1'b1;
        if (cnt == CIW'(N - 1)) begin
          cnt_next   = '0;
          state_next = ST_CHAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_CHAIN: begin
        ctrl.chain = 1'b1;
        if (cnt == CIW'(N - 1)) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Chain head: empty partial result
  assign c_best[0] = '1;
  assign c_med[0]  = '0;
  assign c_any[0]  = 1'b0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic row_hit;
    assign row_hit = (row_x == IXW'(k));

    asmc_cell #(
      .CELL_IDX      (k),
      .ALPHABET_SIZE (N),
      .COST_WIDTH    (COST_WIDTH),
      .CIW           (CIW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .row_hit  (row_hit),
      .wr_col   (col_x[CIW-1:0]),
      .wr_cost  (wr_cost),
      .col      (cnt),
      .row_act  (first_m[k]),
      .col_act  (second_m[cnt]),
      .col_bit  (col_bit),
      .in_best  (c_best[k]),
      .in_med   (c_med[k]),
      .in_any   (c_any[k]),
      .out_best (c_best[k+1]),
      .out_med  (c_med[k+1]),
      .out_any  (c_any[k+1])
    );
  end

  // Saturated answer when no pair exists
  assign best_x   = {{COST_IO_W{1'b0}}, (c_any[N] ? c_best[N] : {COST_WIDTH{1'b1}})};
  assign res_cost = best_x[COST_IO_W-1:0];
  assign res_med  = c_any[N] ? c_med[N] : '0;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {res_med, res_cost};
      m_tuser <= !c_any[N];
    end
  end

endmodule

FILE: src/asmc_cell.sv
module asmc_cell import asmc_pkg::*; #(
  parameter int CELL_IDX      = 0,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int COST_WIDTH    = COST_WIDTH_DEF,
  parameter int CIW           = $clog2(ALPHABET_SIZE)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  asmc_ctrl_t            ctrl,
  input  logic                  row_hit,   // write targets this row
  input  logic [CIW-1:0]        wr_col,
  input  logic [COST_WIDTH-1:0] wr_cost,
  input  logic [CIW-1:0]        col,       // column visited by the sweep
  input  logic                  row_act,   // state of this row is in the first set
  input  logic                  col_act,   // state of this column is in the second set
  input  logic [SET_W-1:0]      col_bit,
  input  logic [COST_WIDTH-1:0] in_best,
  input  logic [SET_W-1:0]      in_med,
  input  logic                  in_any,
  output logic [COST_WIDTH-1:0] out_best,
  output logic [SET_W-1:0]      out_med,
  output logic                  out_any
);

  localparam logic [SET_W-1:0] ROW_BIT =
    (CELL_IDX < SET_W) ? SET_W'(1 << CELL_IDX) : '0;

  logic [COST_WIDTH-1:0] row_cost [ALPHABET_SIZE];
  logic [COST_WIDTH-1:0] rd_cost;
  logic [COST_WIDTH-1:0] row_best;
  logic [SET_W-1:0]      row_med;
  logic                  row_any;

  // One row of the table, written one entry per transaction
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && row_hit) begin
      row_cost[wr_col] <= wr_cost;
    end
  end

  assign rd_cost = row_cost[col];

  // Row minimum over the columns of the second set
  always_ff @(posedge clk) begin
    if (rst) begin
      row_any <= 1'b0;
    end else if (ctrl.clear) begin
      row_any <= 1'b0;
    end else if (ctrl.sweep && row_act && col_act) begin
      row_any <= 1'b1;
      if (!row_any || rd_cost < row_best) begin
        row_best <= rd_cost;
        row_med  <= ROW_BIT | col_bit;
      end else if (rd_cost == row_best) begin
        row_med  <= row_med | ROW_BIT | col_bit;
      end
    end
  end

  // Merge this row into the partial result coming down the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      out_any <= 1'b0;
    end else if (ctrl.clear) begin
      out_any <= 1'b0;
    end else if (ctrl.chain) begin
      out_any <= in_any | row_any;
      if (!row_any) begin
        out_best <= in_best;
        out_med  <= in_med;
      end else if (!in_any || row_best < in_best) begin
        out_best <= row_best;
        out_med  <= row_med;
      end else if (row_best == in_best) begin
        out_best <= row_best;
        out_med  <= row_med | in_med;
      end else begin
        out_best <= in_best;
        out_med  <= in_med;
      end
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import asmc_pkg::*;

  localparam int ALPHA       = ALPHABET_SIZE_DEF;
  localparam int COST_W      = COST_WIDTH_DEF;
  // time allowed after acceptance for a query result to land, plus slack
  localparam int LATENCY     = 2 * ALPHA + 4;
  localparam int CYCLE_LIMIT = 250000;

  typedef struct packed {
    logic [COST_IO_W-1:0] min_cost;
    logic [SET_W-1:0]     median_set;
    logic                 no_pair;
  } lookup_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // first_set[7:0], second_set[15:8], row_state[18:16],
  // column_state[21:19], cost_value[37:22], zero fill[39:38]
  logic [S_TDATA_W-1:0] s_tdata = '0;
  // mode[0]
  logic                 s_tuser = MODE_WRITE;
  logic                 m_tvalid;
  logic                 m_tready = 1'b1;
  // min_cost[15:0], median_set[23:16]
  logic [M_TDATA_W-1:0] m_tdata;
  // no_pair[0]
  logic                 m_tuser;

  // Shadow copy of the cost table and which entries hold a written value
  logic [COST_W-1:0] cost_shadow [ALPHA][ALPHA];
  bit                entry_written [ALPHA][ALPHA];

  lookup_result_t pending_results [$];
  int  errors = 0;
  int  cycle_count = 0;
  int  n_writes = 0;
  int  n_queries = 0;
  int  n_empty = 0;
  int  n_results = 0;
  bit  idle_en = 1'b1;
  int  stall_left = 0;

  ambiguous_state_min_cost_top #(
    .ALPHABET_SIZE(ALPHA),
    .COST_WIDTH   (COST_W)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Least cost over all state pairs; mask restarts on a strict minimum, grows on a tie
  function automatic lookup_result_t predict_lookup(logic [SET_W-1:0] first_set,
                                                    logic [SET_W-1:0] second_set);
    logic [COST_W-1:0] best;
    logic [SET_W-1:0]  median;
    bit                any_pair;
    lookup_result_t    res;
    best     = '1;
    median   = '0;
    any_pair = 1'b0;
    for (int i = 0; i < ALPHA && i < SET_W; i++) begin
      if (first_set[i]) begin
        for (int j = 0; j < ALPHA && j < SET_W; j++) begin
          if (second_set[j]) begin
            any_pair = 1'b1;
            if (cost_shadow[i][j] < best) begin
              best      = cost_shadow[i][j];
              median    = '0;
              median[i] = 1'b1;
              median[j] = 1'b1;
            end else if (cost_shadow[i][j] == best) begin
              median[i] = 1'b1;
              median[j] = 1'b1;
            end
          end
        end
      end
    end
    if (!any_pair) begin
      best   = '1;
      median = '0;
    end
    res.min_cost   = COST_IO_W'(best);
    res.median_set = median;
    res.no_pair    = !any_pair;
    return res;
  endfunction

  // Clear second-set states that would pair with a never-written entry
  function automatic logic [SET_W-1:0] drop_unwritten(logic [SET_W-1:0] first_set,
                                                      logic [SET_W-1:0] second_set);
    logic [SET_W-1:0] kept;
    kept = second_set;
    for (int j = 0; j < ALPHA && j < SET_W; j++)
      for (int i = 0; i < ALPHA && i < SET_W; i++)
        if (first_set[i] && kept[j] && !entry_written[i][j]) kept[j] = 1'b0;
    return kept;
  endfunction

  function automatic logic [SET_W-1:0] pick_set();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return SET_W'(1) << $urandom_range(0, SET_W - 1);
      default: return SET_W'($urandom);
    endcase
  endfunction

  // Drive one transaction, wait for acceptance, then update the shadow model
  task automatic send_item(input logic mode, input logic [SET_W-1:0] first_set,
                           input logic [SET_W-1:0] second_set,
                           input logic [STATE_W-1:0] row, input logic [STATE_W-1:0] col,
                           input logic [COST_IO_W-1:0] cost);
    int gap;
    lookup_result_t res;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {2'b00, cost, col, row, second_set, first_set};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (mode == MODE_WRITE) begin
      if (row < ALPHA && col < ALPHA) begin
        cost_shadow[row][col]   = COST_W'(cost);
        entry_written[row][col] = 1'b1;
      end
      n_writes++;
    end else begin
      res = predict_lookup(first_set, second_set);
      if (res.no_pair) n_empty++;
      pending_results.push_back(res);
      n_queries++;
    end
  endtask

  task automatic write_cost(input int row, input int col, input int cost);
    send_item(MODE_WRITE, SET_W'($urandom), SET_W'($urandom), STATE_W'(row),
              STATE_W'(col), COST_IO_W'(cost));
  endtask

  task automatic query_sets(input logic [SET_W-1:0] first_set,
                            input logic [SET_W-1:0] second_set);
    send_item(MODE_QUERY, first_set, second_set, STATE_W'($urandom),
              STATE_W'($urandom), COST_IO_W'($urandom));
  endtask

  task automatic random_item(input int write_pct, input bit low_costs);
    logic [SET_W-1:0]     a;
    logic [SET_W-1:0]     b;
    logic [COST_IO_W-1:0] cost;
    a = pick_set();
    b = pick_set();
    if (low_costs)
      cost = COST_IO_W'($urandom_range(0, 3));
    else if ($urandom_range(0, 3) == 0)
      cost = COST_IO_W'($urandom_range(0, 7));
    else
      cost = COST_IO_W'($urandom);
    if ($urandom_range(1, 100) <= write_pct)
      send_item(MODE_WRITE, a, b, STATE_W'($urandom), STATE_W'($urandom), cost);
    else
      query_sets(a, drop_unwritten(a, b));
  endtask

  // Extremes, empty sets, ties, all-ones tie, strict-minimum restart, overwrite
  task automatic test_directed();
    write_cost(0, 0, 0);
    write_cost(7, 7, 16'hFFFF);
    write_cost(0, 7, 16'h8000);
    write_cost(7, 0, 16'h7FFF);
    write_cost(1, 1, 9);
    write_cost(1, 2, 5);
    write_cost(2, 1, 5);
    write_cost(2, 2, 7);
    write_cost(3, 3, 20);
    write_cost(3, 4, 10);
    query_sets(8'h01, 8'h01);
    query_sets(8'h80, 8'h80);
    query_sets(8'h00, 8'h01);
    query_sets(8'h01, 8'h00);
    query_sets(8'h00, 8'h00);
    query_sets(8'h06, 8'h06);
    query_sets(8'h02, 8'h06);
    query_sets(8'h08, 8'h18);
    write_cost(3, 4, 30);
    query_sets(8'h08, 8'h18);
    query_sets(8'h80, 8'h01);
    query_sets(8'h01, 8'h80);
    query_sets(8'h81, 8'h81);
  endtask

  // Mixed writes and queries while the table is still filling up
  task automatic test_random_mix(input int count);
    repeat (count) random_item(35, 1'b0);
  endtask

  // Whole table with a few small costs, so most queries hit ties
  task automatic test_tie_storm(input int count);
    for (int r = 0; r < ALPHA; r++)
      for (int c = 0; c < ALPHA; c++)
        write_cost(r, c, $urandom_range(0, 3));
    repeat (count) random_item(15, 1'b1);
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_full_rate(input int count);
    idle_en = 1'b0;
    repeat (count) random_item(35, 1'b0);
  endtask

  // Receiver stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with none pending: m_tdata=%h m_tuser=%b", m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[COST_IO_W-1:0] !== want.min_cost) begin
          $error("min_cost: expected %h, got %h", want.min_cost, m_tdata[COST_IO_W-1:0]);
          errors++;
        end
        if (m_tdata[COST_IO_W+SET_W-1:COST_IO_W] !== want.median_set) begin
          $error("median_set: expected %h, got %h", want.median_set,
                 m_tdata[COST_IO_W+SET_W-1:COST_IO_W]);
          errors++;
        end
        if (m_tuser !== want.no_pair) begin
          $error("no_pair: expected %b, got %b", want.no_pair, m_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix(700);
    test_tie_storm(236);
    test_full_rate(330);

    @(negedge clk);
    s_tvalid <= 1'b0;

    // drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end

    $display("Covered %0d table writes and %0d lookups (%0d with an empty set), %0d results",
             n_writes, n_queries, n_empty, n_results);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
